/* rtl/plb_pkg.sv */
`timescale 1ns / 1ps
package plb_pkg;

  localparam int unsigned LEVELS = 64;
  localparam int unsigned IDX_W  = $clog2(LEVELS);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_PRUNE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_SUM,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_clr;   // start search pass
    logic scan_step;  // one entry of search/prune
    logic apply;      // write the matched or free entry
    logic sum_clr;    // start sum pass
    logic sum_step;   // one entry of sum/best pass
    logic finish;     // register result
    logic out_take;   // result handed over
  } plb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;       // counter at final entry
    logic out_valid;
  } plb_sts_t;

endpackage

/* rtl/plb_ram.sv */
`timescale 1ns / 1ps
module plb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/plb_ctrl.sv */
`timescale 1ns / 1ps
module plb_ctrl
  import plb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     out_stall_i,
  input  plb_sts_t sts_i,
  output plb_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.out_take = sts_i.out_valid && !out_stall_i;
    // accept once the previous result has gone or leaves now
    in_stall_o = (state_q != S_IDLE) || (sts_i.out_valid && out_stall_i);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        cmd_o.sum_clr = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/plb_dp.sv */
`timescale 1ns / 1ps
module plb_dp
  import plb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plb_cmd_t           cmd_i,
  output plb_sts_t           sts_o,
  input  logic [1:0]         action_i,
  input  logic               is_bid_i,
  input  logic [31:0]        price_i,
  input  logic signed [31:0] amount_i,
  output logic               out_valid_o,
  output logic [31:0]        top_bid_o,
  output logic [31:0]        top_ask_o,
  output logic [32:0]        mid_half_ticks_o,
  output logic signed [47:0] bid_volume_o,
  output logic signed [47:0] ask_volume_o,
  output logic [1:0]         status_o
);

  // request registers
  action_e            act_q;
  logic               bid_q;
  logic [31:0]        price_q;
  logic signed [31:0] amt_q;

  logic [LEVELS-1:0] bvld_q, avld_q;

  // scan pointer runs one ahead of the registered ram read
  logic [IDX_W:0] ptr_q;       // issued read address, up to LEVELS
  logic           rd_q;        // read data valid this cycle
  logic [IDX_W-1:0] rdi_q;     // index of data on ram output
  logic [IDX_W-1:0] raddr;

  logic [31:0]        bp_rd, ap_rd;
  logic signed [31:0] ba_rd, aa_rd;
  logic        b_we, a_we;
  logic [IDX_W-1:0] waddr;
  logic [31:0] wamt;

  logic               hit_q, free_q;
  logic [IDX_W-1:0]   hit_idx_q, free_idx_q;
  logic signed [31:0] hit_amt_q;

  logic        hb_q, ha_q;
  logic [31:0] bb_q, ba_q;
  logic signed [47:0] bs_q, as_q;

  logic step;
  assign step  = cmd_i.scan_step || cmd_i.sum_step;
  assign raddr = ptr_q[IDX_W-1:0];
  assign sts_o.last = rd_q && (rdi_q == IDX_W'(LEVELS - 1));
  assign sts_o.out_valid = out_valid_o;

  // selected-side view of the scanned entry
  logic               s_vld;
  logic [31:0]        s_pr;
  logic signed [31:0] s_am;
  assign s_vld = bid_q ? bvld_q[rdi_q] : avld_q[rdi_q];
  assign s_pr  = bid_q ? bp_rd : ap_rd;
  assign s_am  = bid_q ? ba_rd : aa_rd;

  // apply decision
  logic signed [32:0] sum33;
  logic signed [31:0] sat_amt;
  logic               sat;
  assign sum33 = 33'(hit_amt_q) + 33'(amt_q);
  always_comb begin
    sat = 1'b0;
    sat_amt = sum33[31:0];
    if (sum33 > 33'sd2147483647) begin
      sat = 1'b1;
      sat_amt = 32'sh7fffffff;
    end else if (sum33 < -33'sd2147483648) begin
      sat = 1'b1;
      sat_amt = 32'sh80000000;
    end
  end

  logic ins, upd, del, full;
  logic [1:0] st_d;
  always_comb begin
    ins = 1'b0; upd = 1'b0; del = 1'b0; full = 1'b0;
    wamt = amt_q;
    st_d = ST_OK;
    case (act_q)
      ACT_ADD: begin
        if (hit_q) begin
          upd = 1'b1; wamt = sat_amt;
          if (sat) st_d = ST_SATURATED;
        end else if (free_q) ins = 1'b1;
        else full = 1'b1;
      end
      ACT_UPDATE: begin
        if (hit_q) begin
          if (amt_q == '0) del = 1'b1;
          else upd = 1'b1;
        end else if (amt_q > 0) begin
          if (free_q) ins = 1'b1;
          else full = 1'b1;
        end
      end
      default: ;
    endcase
    if (full) st_d = ST_FULL;
  end

  assign waddr = hit_q ? hit_idx_q : free_idx_q;
  logic we;
  assign we   = cmd_i.apply && (ins || upd);
  assign b_we = we && bid_q;
  assign a_we = we && !bid_q;

  plb_ram #(.WIDTH(32), .DEPTH(LEVELS)) u_bid_price (
    .clk_i, .we_i(b_we && ins), .waddr_i(waddr), .wdata_i(price_q),
    .raddr_i(raddr), .rdata_o(bp_rd));
  plb_ram #(.WIDTH(32), .DEPTH(LEVELS)) u_bid_amt (
    .clk_i, .we_i(b_we), .waddr_i(waddr), .wdata_i(wamt),
    .raddr_i(raddr), .rdata_o(ba_rd));
  plb_ram #(.WIDTH(32), .DEPTH(LEVELS)) u_ask_price (
    .clk_i, .we_i(a_we && ins), .waddr_i(waddr), .wdata_i(price_q),
    .raddr_i(raddr), .rdata_o(ap_rd));
  plb_ram #(.WIDTH(32), .DEPTH(LEVELS)) u_ask_amt (
    .clk_i, .we_i(a_we), .waddr_i(waddr), .wdata_i(wamt),
    .raddr_i(raddr), .rdata_o(aa_rd));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_e'(action_i);
      bid_q   <= is_bid_i;
      price_q <= price_i;
      amt_q   <= amount_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q <= '0;
      avld_q <= '0;
      ptr_q  <= '0;
      rd_q   <= 1'b0;
      rdi_q  <= '0;
      out_valid_o <= 1'b0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (cmd_i.scan_clr || cmd_i.sum_clr) begin
        ptr_q <= '0;
        rd_q  <= 1'b0;
      end else if (step) begin
        if (ptr_q != (IDX_W+1)'(LEVELS)) ptr_q <= ptr_q + 1'b1;
        rd_q  <= (ptr_q != (IDX_W+1)'(LEVELS));
        rdi_q <= raddr;
      end
      if (cmd_i.scan_clr) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        if (action_e'(action_i) == ACT_CLEAR) begin
          bvld_q <= '0;
          avld_q <= '0;
        end
      end
      if (cmd_i.scan_step && rd_q) begin
        if (s_vld && s_pr == price_q && !hit_q) hit_q <= 1'b1;
        if (!s_vld && !free_q) free_q <= 1'b1;
        if (act_q == ACT_PRUNE) begin
          if (bvld_q[rdi_q] && ba_rd <= 0) bvld_q[rdi_q] <= 1'b0;
          if (avld_q[rdi_q] && aa_rd <= 0) avld_q[rdi_q] <= 1'b0;
        end
      end
      if (cmd_i.apply) begin
        if (ins) begin
          if (bid_q) bvld_q[free_idx_q] <= 1'b1;
          else avld_q[free_idx_q] <= 1'b1;
        end
        if (del) begin
          if (bid_q) bvld_q[hit_idx_q] <= 1'b0;
          else avld_q[hit_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.finish) out_valid_o <= 1'b1;
      else if (cmd_i.out_take) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && rd_q) begin
      if (s_vld && s_pr == price_q && !hit_q) begin
        hit_idx_q <= rdi_q;
        hit_amt_q <= s_am;
      end
      if (!s_vld && !free_q) free_idx_q <= rdi_q;
    end
    if (cmd_i.apply) status_o <= st_d;
    if (cmd_i.sum_clr) begin
      hb_q <= 1'b0; ha_q <= 1'b0;
      bb_q <= '0;   ba_q <= '0;
      bs_q <= '0;   as_q <= '0;
    end else if (cmd_i.sum_step && rd_q) begin
      if (bvld_q[rdi_q]) begin
        bs_q <= bs_q + 48'(ba_rd);
        if (!hb_q || bp_rd > bb_q) begin
          bb_q <= bp_rd; hb_q <= 1'b1;
        end
      end
      if (avld_q[rdi_q]) begin
        as_q <= as_q + 48'(aa_rd);
        if (!ha_q || ap_rd < ba_q) begin
          ba_q <= ap_rd; ha_q <= 1'b1;
        end
      end
    end
    if (cmd_i.finish) begin
      top_bid_o <= bb_q;
      top_ask_o <= ba_q;
      mid_half_ticks_o <= (hb_q && ha_q) ? ({1'b0, bb_q} + {1'b0, ba_q}) : '0;
      bid_volume_o <= bs_q;
      ask_volume_o <= as_q;
    end
  end

`ifndef SYNTH
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && hit_q && act_q != ACT_PRUNE) |->
      (bid_q ? bvld_q[hit_idx_q] : avld_q[hit_idx_q]))
    else $error("matched level not valid");
  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && free_q && !hit_q) |->
      !(bid_q ? bvld_q[free_idx_q] : avld_q[free_idx_q]))
    else $error("free slot occupied");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cmd_i.out_take) |=> out_valid_o)
    else $error("result dropped");
`endif

endmodule

/* rtl/price_level_book.sv */
`timescale 1ns / 1ps
// one request is handled at a time, from accept through both passes to the result register
// the first pass searches the side (or prunes), the second forms best prices and volumes
// a new request is taken no earlier than the edge at which the previous result leaves
// reset (async, active low) empties both sides and drops any pending result
module price_level_book
  import plb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic               is_bid_i,
  input  logic [31:0]        price_i,
  input  logic signed [31:0] amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        top_bid_o,
  output logic [31:0]        top_ask_o,
  output logic [32:0]        mid_half_ticks_o,
  output logic signed [47:0] bid_volume_o,
  output logic signed [47:0] ask_volume_o,
  output logic [1:0]         status_o
);

  // command and status between sequencer and level datapath
  plb_cmd_t cmd;
  plb_sts_t sts;

  // sequencer: idle, search/prune pass, write, sum pass, publish
  plb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_stall_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // level tables, valid bits, accumulators and the output register
  plb_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .action_i,
    .is_bid_i,
    .price_i,
    .amount_i,
    .out_valid_o,
    .top_bid_o,
    .top_ask_o,
    .mid_half_ticks_o,
    .bid_volume_o,
    .ask_volume_o,
    .status_o
  );

endmodule
